// ===== src/mep_pkg.sv =====
// Shared types, constants and fixed-point helpers for the escape-time pixel block.
package mep_pkg;

  localparam int FRAC_BITS = 28;
  localparam int COORD_BITS = 12;
  localparam int ITER_W = 12;
  localparam int COLOR_W = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W = 64;
  localparam int SH_W = PROD_W - FRAC_BITS;

  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_X = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_Y = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ITER = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ESC_RSQ = 3'd5;

  localparam logic signed [31:0] RST_CENTER_X = -32'sd201326592;
  localparam logic signed [31:0] RST_CENTER_Y = 32'sd0;
  localparam logic [30:0] RST_STEP_X = 31'd671089;
  localparam logic [30:0] RST_STEP_Y = 31'd671089;
  localparam logic [ITER_W-1:0] RST_MAX_ITER = 12'd240;
  localparam logic [30:0] RST_ESC_RSQ = 31'd1073741824;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        step_x;
    logic [30:0]        step_y;
    logic [ITER_W-1:0]  max_iter;
    logic [30:0]        esc_rsq;
  } cfg_t;

  typedef struct packed {
    logic              escaped;
    logic [ITER_W-1:0] iter_count;
  } res_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Residue mod 255 of a 15-bit value: 256 is 1 mod 255, so the two bytes are folded.
  function automatic logic [COLOR_W-1:0] mod255(input logic [14:0] x);
    logic [8:0] s;
    s = 9'(x[14:8]) + 9'(x[7:0]);
    if (s >= 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

endpackage

// ===== src/mep_mul.sv =====
// Shared signed 32x32 multiplier with a registered product.
module mep_mul (
  input  logic                              clk,
  input  logic signed [31:0]                a,
  input  logic signed [31:0]                b,
  output logic signed [mep_pkg::PROD_W-1:0] p_r
);

  logic signed [mep_pkg::PROD_W-1:0] p_nxt;

  assign p_nxt = 64'(a) * 64'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ===== src/mep_core.sv =====
// Sequencer and orbit datapath that drive the shared multiplier for one pixel.
module mep_core #(
  parameter int COORD_BITS = mep_pkg::COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [COORD_BITS-1:0]      dx,
  input  logic signed [COORD_BITS-1:0]      dy,
  input  mep_pkg::cfg_t                     cfg,
  output logic signed [31:0]                mul_a,
  output logic signed [31:0]                mul_b,
  input  logic signed [mep_pkg::PROD_W-1:0] mul_p,
  output logic                              idle,
  output logic                              res_valid,
  output mep_pkg::res_t                     res,
  input  logic                              res_ready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CX   = 4'd1;
  localparam logic [3:0] S_CY   = 4'd2;
  localparam logic [3:0] S_CI   = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_SQR  = 4'd5;
  localparam logic [3:0] S_SQI  = 4'd6;
  localparam logic [3:0] S_CRS  = 4'd7;
  localparam logic [3:0] S_TST  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam int SH_W = mep_pkg::SH_W;
  localparam int IW = mep_pkg::ITER_W;

  logic [3:0] state_r, state_nxt;
  logic signed [COORD_BITS-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [31:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [31:0] zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [SH_W-1:0] rr_r, rr_nxt, ii_r, ii_nxt, ri_r, ri_nxt;
  logic [IW-1:0] n_r, n_nxt;
  logic esc_r, esc_nxt;

  logic signed [SH_W-1:0] p_sh;
  logic signed [SH_W:0]   mag_sq;
  logic                   over;

  // Arithmetic shift of the product floors toward minus infinity.
  assign p_sh = mul_p[mep_pkg::PROD_W-1:mep_pkg::FRAC_BITS];
  assign mag_sq = (SH_W+1)'(rr_r) + (SH_W+1)'(ii_r);
  assign over = mag_sq > signed'((SH_W+1)'({1'b0, cfg.esc_rsq}));

  always_comb begin
    case (state_r)
      S_CX: begin
        mul_a = 32'(dx_r);
        mul_b = signed'({1'b0, cfg.step_x});
      end
      S_CY: begin
        mul_a = 32'(dy_r);
        mul_b = signed'({1'b0, cfg.step_y});
      end
      S_SQR: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
      S_SQI: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      default: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    cr_nxt = cr_r;
    ci_nxt = ci_r;
    zr_nxt = zr_r;
    zi_nxt = zi_r;
    rr_nxt = rr_r;
    ii_nxt = ii_r;
    ri_nxt = ri_r;
    n_nxt = n_r;
    esc_nxt = esc_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          dx_nxt = dx;
          dy_nxt = dy;
          state_nxt = S_CX;
        end
      end
      S_CX: begin
        state_nxt = S_CY;
      end
      S_CY: begin
        cr_nxt = mep_pkg::sat32(64'(cfg.center_x) + mul_p);
        state_nxt = S_CI;
      end
      S_CI: begin
        ci_nxt = mep_pkg::sat32(64'(cfg.center_y) + mul_p);
        // The orbit starts at zero, so all three products start at zero.
        rr_nxt = '0;
        ii_nxt = '0;
        ri_nxt = '0;
        n_nxt = '0;
        esc_nxt = 1'b0;
        if (cfg.max_iter == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        zr_nxt = mep_pkg::sat32(64'(rr_r) - 64'(ii_r) + 64'(cr_r));
        zi_nxt = mep_pkg::sat32(64'(ri_r) + 64'(ri_r) + 64'(ci_r));
        state_nxt = S_SQR;
      end
      S_SQR: begin
        state_nxt = S_SQI;
      end
      S_SQI: begin
        rr_nxt = p_sh;
        state_nxt = S_CRS;
      end
      S_CRS: begin
        ii_nxt = p_sh;
        state_nxt = S_TST;
      end
      S_TST: begin
        ri_nxt = p_sh;
        if (over) begin
          esc_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (n_r + IW'(1) == cfg.max_iter) begin
          n_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          n_nxt = n_r + IW'(1);
          state_nxt = S_UPD;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    cr_r <= cr_nxt;
    ci_r <= ci_nxt;
    zr_r <= zr_nxt;
    zi_r <= zi_nxt;
    rr_r <= rr_nxt;
    ii_r <= ii_nxt;
    ri_r <= ri_nxt;
    n_r <= n_nxt;
    esc_r <= esc_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.escaped = esc_r;
  assign res.iter_count = n_r;

endmodule

// ===== src/mandelbrot_escape_time_pixel_top.sv =====
// Escape-time pixel evaluator: configuration registers, stream ports and result register.
//
// Each accepted pixel offset is mapped to c = center + offset * step and the orbit
// z = z*z + c is iterated from zero until |z|^2 exceeds the squared escape radius or
// max_iter steps have run. All arithmetic goes through one registered 32x32 multiplier
// that forms three products per orbit step, so each step runs through the states S_UPD,
// S_SQR, S_SQI, S_CRS and S_TST. A pixel runs k steps (k = iter_count + 1 on escape,
// k = max_iter otherwise); the next pixel is taken once the result has moved into the
// output register, which holds it until it is transferred. Configuration must be written
// only while no pixel is in flight; the block itself does not enforce it.
module mandelbrot_escape_time_pixel_top #(
  parameter int COORD_BITS = mep_pkg::COORD_BITS,
  localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [IN_W-1:0]                     in_tdata,   // pixel_dx, pixel_dy
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [39:0]                         out_tdata,  // iter_count, red, green, blue
  output logic                                out_tuser,  // escaped
  input  logic                                cfg_we,
  input  logic [mep_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mep_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  mep_pkg::cfg_t cfg_r, cfg_nxt;
  mep_pkg::res_t res;
  logic          res_valid, res_ready, core_idle;
  logic signed [31:0] mul_a, mul_b;
  logic signed [mep_pkg::PROD_W-1:0] mul_p;

  logic        out_valid_r, out_valid_nxt;
  logic        out_esc_r;
  logic [mep_pkg::ITER_W-1:0]  out_iter_r;
  logic [mep_pkg::COLOR_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic [14:0] iter_w;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        mep_pkg::CFG_CENTER_X: cfg_nxt.center_x = signed'(cfg_wdata);
        mep_pkg::CFG_CENTER_Y: cfg_nxt.center_y = signed'(cfg_wdata);
        mep_pkg::CFG_STEP_X:   cfg_nxt.step_x = cfg_wdata[30:0];
        mep_pkg::CFG_STEP_Y:   cfg_nxt.step_y = cfg_wdata[30:0];
        mep_pkg::CFG_MAX_ITER: cfg_nxt.max_iter = cfg_wdata[mep_pkg::ITER_W-1:0];
        mep_pkg::CFG_ESC_RSQ:  cfg_nxt.esc_rsq = cfg_wdata[30:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x <= mep_pkg::RST_CENTER_X;
      cfg_r.center_y <= mep_pkg::RST_CENTER_Y;
      cfg_r.step_x <= mep_pkg::RST_STEP_X;
      cfg_r.step_y <= mep_pkg::RST_STEP_Y;
      cfg_r.max_iter <= mep_pkg::RST_MAX_ITER;
      cfg_r.esc_rsq <= mep_pkg::RST_ESC_RSQ;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mep_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  mep_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && in_tready),
    .dx        (signed'(in_tdata[COORD_BITS-1:0])),
    .dy        (signed'(in_tdata[2*COORD_BITS-1:COORD_BITS])),
    .cfg       (cfg_r),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_p     (mul_p),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign in_tready = core_idle;
  assign res_ready = !out_valid_r || out_tready;

  // The count is zero when the point never escapes, so the colors come out zero too.
  assign iter_w = 15'(res.iter_count);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_esc_r <= res.escaped;
      out_iter_r <= res.iter_count;
      out_red_r <= mep_pkg::mod255(iter_w * 15'd4);
      out_green_r <= mep_pkg::mod255(iter_w * 15'd5);
      out_blue_r <= mep_pkg::mod255(iter_w * 15'd6);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_esc_r;
  assign out_tdata = {4'd0, out_blue_r, out_green_r, out_red_r, out_iter_r};

endmodule

// ===== tb/sv/escape_time_checker.sv =====
// Stream monitor that predicts each pixel's escape result and compares it with the block's output.
`timescale 1ns / 1ps

module escape_time_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_dx, pixel_dy
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // iter_count, red, green, blue
  input  logic        out_tuser,  // escaped
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          n_pending,
  output int          n_fail,
  output int          n_checked,
  output int          n_escaped
);

  localparam int FRAC = 28;

  typedef struct packed {
    logic        escaped;
    logic [11:0] iter_count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_result_t;

  typedef struct packed {
    logic [11:0]   dx;
    logic [11:0]   dy;
    pixel_result_t res;
  } pixel_expect_t;

  mep_pkg::cfg_t view;
  pixel_expect_t awaited_pixels[$];
  int            fails = 0;
  int            checked = 0;
  int            escapes = 0;

  function automatic int clamp32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // Exact 64-bit product; the arithmetic shift rounds toward minus infinity.
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic pixel_result_t predict_escape(mep_pkg::cfg_t v, logic signed [11:0] dx,
                                                   logic signed [11:0] dy);
    pixel_result_t r;
    int            cr;
    int            ci;
    int            zr;
    int            zi;
    int            limit;
    longint        rr;
    longint        ii;
    longint        ri;
    r = '0;
    cr = clamp32(longint'(v.center_x) + longint'(dx) * longint'(v.step_x));
    ci = clamp32(longint'(v.center_y) + longint'(dy) * longint'(v.step_y));
    zr = 0;
    zi = 0;
    limit = int'(v.max_iter);
    for (int n = 0; n < limit; n++) begin
      rr = qmul(zr, zr);
      ii = qmul(zi, zi);
      ri = qmul(zr, zi);
      zr = clamp32(rr - ii + cr);
      zi = clamp32(2 * ri + ci);
      // The escape test uses the unclamped sum of the two squares.
      if (qmul(zr, zr) + qmul(zi, zi) > longint'(v.esc_rsq)) begin
        r.escaped = 1'b1;
        r.iter_count = 12'(n);
        r.red = 8'((n * 4) % 255);
        r.green = 8'((n * 5) % 255);
        r.blue = 8'((n * 6) % 255);
        break;
      end
    end
    return r;
  endfunction

  task automatic compare_field(string fname, int want, int got, pixel_expect_t e);
    if (want != got) begin
      $display("%0t: pixel (%0d,%0d) %s expected %0d got %0d", $time, $signed(e.dx),
               $signed(e.dy), fname, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : track
    pixel_expect_t e;
    pixel_result_t got;
    if (!rst_n) begin
      view.center_x = -32'sd201326592;
      view.center_y = 32'sd0;
      view.step_x = 31'd671089;
      view.step_y = 31'd671089;
      view.max_iter = 12'd240;
      view.esc_rsq = 31'd1073741824;
      awaited_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          mep_pkg::CFG_CENTER_X: view.center_x = cfg_wdata;
          mep_pkg::CFG_CENTER_Y: view.center_y = cfg_wdata;
          mep_pkg::CFG_STEP_X:   view.step_x = cfg_wdata[30:0];
          mep_pkg::CFG_STEP_Y:   view.step_y = cfg_wdata[30:0];
          mep_pkg::CFG_MAX_ITER: view.max_iter = cfg_wdata[11:0];
          mep_pkg::CFG_ESC_RSQ:  view.esc_rsq = cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        e.dx = in_tdata[11:0];
        e.dy = in_tdata[23:12];
        e.res = predict_escape(view, e.dx, e.dy);
        awaited_pixels.push_back(e);
      end
      if (out_tvalid && out_tready) begin
        got.escaped = out_tuser;
        got.iter_count = out_tdata[11:0];
        got.red = out_tdata[19:12];
        got.green = out_tdata[27:20];
        got.blue = out_tdata[35:28];
        if (awaited_pixels.size() == 0) begin
          $display("%0t: result with no pixel waiting, expected none got escaped %0d iter %0d",
                   $time, got.escaped, got.iter_count);
          fails++;
        end else begin
          e = awaited_pixels.pop_front();
          compare_field("escaped", e.res.escaped, got.escaped, e);
          compare_field("iter_count", e.res.iter_count, got.iter_count, e);
          compare_field("red", e.res.red, got.red, e);
          compare_field("green", e.res.green, got.green, e);
          compare_field("blue", e.res.blue, got.blue, e);
          checked++;
          if (e.res.escaped) escapes++;
        end
      end
    end
    n_pending <= awaited_pixels.size();
    n_fail <= fails;
    n_checked <= checked;
    n_escaped <= escapes;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the escape-time pixel testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD = 10;
  localparam int IN_W = ((2 * mep_pkg::COORD_BITS + 7) / 8) * 8;
  // A few pixels at the 4095 step limit dominate the slowest correct run.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int STALL_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [mep_pkg::CFG_ADDR_W-1:0] CFG_HOLE_LO = 3'd6;
  localparam logic [mep_pkg::CFG_ADDR_W-1:0] CFG_HOLE_HI = 3'd7;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [39:0]     out_tdata;
  logic            out_tuser;
  logic            cfg_we = 1'b0;
  logic [2:0]      cfg_addr = '0;
  logic [31:0]     cfg_wdata = '0;

  int n_pending;
  int n_fail;
  int n_checked;
  int n_escaped;
  int pixels_sent = 0;
  int views_loaded = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 65;
  bit hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  mandelbrot_escape_time_pixel_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  escape_time_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .n_pending  (n_pending),
    .n_fail     (n_fail),
    .n_checked  (n_checked),
    .n_escaped  (n_escaped)
  );

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_view(logic [31:0] cx, logic [31:0] cy, logic [31:0] sx,
                          logic [31:0] sy, logic [31:0] iters, logic [31:0] rsq);
    write_reg(mep_pkg::CFG_CENTER_X, cx);
    write_reg(mep_pkg::CFG_CENTER_Y, cy);
    write_reg(mep_pkg::CFG_STEP_X, sx);
    write_reg(mep_pkg::CFG_STEP_Y, sy);
    write_reg(mep_pkg::CFG_MAX_ITER, iters);
    write_reg(mep_pkg::CFG_ESC_RSQ, rsq);
    cfg_we <= 1'b0;
    views_loaded++;
  endtask

  // in_tvalid stays high from one pixel to the next unless an idle cycle is drawn.
  task automatic send_pixel(logic [11:0] dx, logic [11:0] dy);
    if (pixels_sent < 290) begin
      send_idle_pct = 28;
      recv_idle_pct = 65;
    end else if (pixels_sent < 580) begin
      send_idle_pct = 65;
      recv_idle_pct = 28;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {dy, dx};
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  // Stop offering pixels and wait until every expected result has been transferred.
  task automatic finish_burst();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  function automatic logic [11:0] pick_offset(int span);
    if (span >= 2048) return 12'($urandom);
    return 12'($urandom_range(2 * span) - span);
  endfunction

  task automatic random_pixels(int count, int span);
    for (int k = 0; k < count; k++) begin
      send_pixel(pick_offset(span), pick_offset(span));
    end
    finish_burst();
  endtask

  // The receiver draws its ready each cycle; once asked, it holds off for a long stretch.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped by the cycle limit after %0d cycles", cycles);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Writes to unused indexes must leave the reset view untouched.
    write_reg(CFG_HOLE_LO, 32'hDEAD_BEEF);
    write_reg(CFG_HOLE_HI, 32'h0000_0001);
    cfg_we <= 1'b0;

    // Reset view: corners, axes, points inside the set and near its boundary.
    send_pixel(12'sd0, 12'sd0);         send_pixel(-12'sd2048, -12'sd2048);
    send_pixel(12'sd2047, 12'sd2047);   send_pixel(-12'sd2048, 12'sd2047);
    send_pixel(12'sd2047, -12'sd2048);  send_pixel(-12'sd2048, 12'sd0);
    send_pixel(12'sd2047, 12'sd0);      send_pixel(12'sd0, -12'sd2048);
    send_pixel(12'sd0, 12'sd2047);      send_pixel(-12'sd1, -12'sd1);
    send_pixel(12'sd1, 12'sd0);         send_pixel(12'sd300, 12'sd0);
    send_pixel(-12'sd500, 12'sd0);      send_pixel(-12'sd499, 12'sd0);
    send_pixel(12'sd100, 12'sd400);     send_pixel(12'sd400, 12'sd0);
    send_pixel(-12'sd2048, -12'sd1);    send_pixel(12'sd1, -12'sd2048);
    send_pixel(-12'sd300, 12'sd0);      send_pixel(12'sd200, -12'sd250);
    finish_burst();

    // Plane from -2.75 to 1.25 on the real axis and -2 to 2 on the imaginary axis, short iteration limit.
    set_view(-32'sd201326592, 32'sd0, 32'd262144, 32'd262144, 32'd16, 32'd1073741824);
    random_pixels(160, 2048);

    // Zero iteration limit; ignored upper bits set on the limit and the steps.
    set_view(32'h0000_0000, 32'h0000_0000, 32'h8004_0000, 32'hC000_1000, 32'hFFFF_F000,
             32'h4000_0000);
    random_pixels(30, 2048);

    // Single step, zero radius, zero and full steps.
    set_view($urandom, $urandom, 32'd0, 32'h7FFF_FFFF, 32'd1, 32'd0);
    random_pixels(50, 2048);

    // Centers and steps at their extremes drive most coordinates into saturation.
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd8, 32'h7FFF_FFFF);
    random_pixels(80, 2048);
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd12,
             32'h7FFF_FFFF);
    random_pixels(60, 2048);

    // Largest iteration limit and radius, only a few pixels since bounded ones are slow.
    set_view(-32'sd201326592, 32'sd26843546, 32'd262144, 32'd262144, 32'h0000_0FFF,
             32'h7FFF_FFFF);
    random_pixels(8, 2048);

    // Random views near the set, alternating wide and zoomed pixel spans.
    for (int v = 0; v < 4; v++) begin
      set_view(32'($urandom_range(32'h4000_0000)) - 32'h2000_0000,
               32'($urandom_range(32'h4000_0000)) - 32'h2000_0000,
               ($urandom & 32'h8000_0000) | $urandom_range(32'h0008_0000),
               ($urandom & 32'h8000_0000) | $urandom_range(32'h0008_0000),
               ($urandom & 32'hFFFF_F000) | $urandom_range(64, 1),
               $urandom_range(32'h7FFF_FFFF));
      random_pixels(60, (v % 2 == 0) ? 2048 : 64);
    end

    // Everyday view with a moderate limit.
    set_view(-32'sd201326592, 32'sd26843546, 32'd671089, 32'd671089, 32'd40, 32'd1073741824);
    random_pixels(120, 2048);

    // Short pixels while the receiver holds off, so the block backs up onto its input.
    set_view(-32'sd201326592, 32'sd0, 32'd262144, 32'd262144, 32'd3, 32'd1073741824);
    hold_req = 1'b1;
    random_pixels(120, 2048);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d pixel results across %0d views: %0d escaped, %0d stayed bounded.",
             n_checked, views_loaded, n_escaped, n_checked - n_escaped);
    if (n_fail == 0 && n_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
